### rtl/ppot_pkg.sv
package ppot_pkg;

   localparam int MAX_COLS_DEF = 512;
   localparam int MAX_ROWS_DEF = 512;

   // Points whose |z| is below this many Q16.16 units are too near the camera plane.
   localparam logic signed [31:0] NEAR_LIMIT = 32'sd7;

   localparam logic [2:0] ST_VISIBLE  = 3'd0;
   localparam logic [2:0] ST_NEAR     = 3'd1;
   localparam logic [2:0] ST_OUTSIDE  = 3'd2;
   localparam logic [2:0] ST_OCCLUDED = 3'd3;
   localparam logic [2:0] ST_WRITTEN  = 3'd4;

   localparam logic [2:0] CSR_FOCAL_X     = 3'd0;
   localparam logic [2:0] CSR_FOCAL_Y     = 3'd1;
   localparam logic [2:0] CSR_CENTER_X    = 3'd2;
   localparam logic [2:0] CSR_CENTER_Y    = 3'd3;
   localparam logic [2:0] CSR_DEPTH_SCALE = 3'd4;
   localparam logic [2:0] CSR_IMAGE_COLS  = 3'd5;
   localparam logic [2:0] CSR_IMAGE_ROWS  = 3'd6;

   typedef struct packed {
      logic [31:0] focal_x;
      logic [31:0] focal_y;
      logic [31:0] center_x;
      logic [31:0] center_y;
      logic [31:0] depth_scale;
      logic [9:0]  image_cols;
      logic [9:0]  image_rows;
   } cfg_type;

   // Request fields carried alongside the ratio dividers.
   typedef struct packed {
      logic               proj;
      logic               near;
      logic               sgn_x;
      logic signed [31:0] z;
      logic [31:0]        radius;
      logic [8:0]         wcol;
      logic [8:0]         wrow;
      logic [15:0]        wdata;
   } front_tag_type;

   // Fields carried alongside the tolerance divider.
   typedef struct packed {
      logic [2:0]  status;
      logic        depth_nz;
      logic [49:0] diff;
      logic [9:0]  pcol;
      logic [9:0]  prow;
   } back_tag_type;

endpackage

### rtl/ppot_ram.sv
module ppot_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/ppot_div.sv
module ppot_div #(
   parameter int NW = 48,
   parameter int DW = 32,
   parameter int TW = 1
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          in_valid,
   input  logic [NW-1:0] num,
   input  logic [DW-1:0] den,
   input  logic [TW-1:0] tag_in,
   output logic          out_valid,
   output logic [NW-1:0] quo,
   output logic [TW-1:0] tag_out
);

   logic [DW-1:0] rem_ff [NW];
   logic [NW-1:0] acc_ff [NW];
   logic [DW-1:0] den_ff [NW];
   logic [TW-1:0] tag_ff [NW];
   logic          vld_ff [NW];

   // One restoring step: the dividend shifts out of the top of acc while
   // quotient bits enter at the bottom.
   function automatic logic [DW+NW-1:0] div_step(input logic [DW-1:0] rem,
                                                 input logic [NW-1:0] acc,
                                                 input logic [DW-1:0] d);
      logic [DW:0] trial;
      logic        ge;
      trial = {rem, acc[NW-1]};
      ge    = (trial >= {1'b0, d});
      if (ge) begin
         trial = trial - {1'b0, d};
      end
      return {trial[DW-1:0], acc[NW-2:0], ge};
   endfunction

   for (genvar i = 0; i < NW; i++) begin : g_stage
      logic [DW-1:0]    rem_src;
      logic [NW-1:0]    acc_src;
      logic [DW-1:0]    den_src;
      logic [TW-1:0]    tag_src;
      logic             vld_src;
      logic [DW+NW-1:0] res_in;

      if (i == 0) begin : g_head
         assign rem_src = '0;
         assign acc_src = num;
         assign den_src = den;
         assign tag_src = tag_in;
         assign vld_src = in_valid;
      end else begin : g_body
         assign rem_src = rem_ff[i-1];
         assign acc_src = acc_ff[i-1];
         assign den_src = den_ff[i-1];
         assign tag_src = tag_ff[i-1];
         assign vld_src = vld_ff[i-1];
      end

      assign res_in = div_step(rem_src, acc_src, den_src);

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[i] <= 1'b0;
         end else begin
            vld_ff[i] <= vld_src;
         end
         rem_ff[i] <= res_in[DW+NW-1:NW];
         acc_ff[i] <= res_in[NW-1:0];
         den_ff[i] <= den_src;
         tag_ff[i] <= tag_src;
      end
   end

   assign out_valid = vld_ff[NW-1];
   assign quo       = acc_ff[NW-1];
   assign tag_out   = tag_ff[NW-1];

endmodule

### rtl/ppot_csr.sv
module ppot_csr (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [2:0]        csr_index,
   input  logic [31:0]       csr_wdata,
   output ppot_pkg::cfg_type cfg
);
   import ppot_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_FOCAL_X:     cfg_in.focal_x     = csr_wdata;
            CSR_FOCAL_Y:     cfg_in.focal_y     = csr_wdata;
            CSR_CENTER_X:    cfg_in.center_x    = csr_wdata;
            CSR_CENTER_Y:    cfg_in.center_y    = csr_wdata;
            CSR_DEPTH_SCALE: cfg_in.depth_scale = csr_wdata;
            CSR_IMAGE_COLS:  cfg_in.image_cols  = csr_wdata[9:0];
            CSR_IMAGE_ROWS:  cfg_in.image_rows  = csr_wdata[9:0];
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.focal_x     <= '0;
         cfg_ff.focal_y     <= '0;
         cfg_ff.center_x    <= '0;
         cfg_ff.center_y    <= '0;
         cfg_ff.depth_scale <= 32'd65536;
         cfg_ff.image_cols  <= 10'd512;
         cfg_ff.image_rows  <= 10'd512;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

endmodule

### rtl/point_projection_occlusion_test.sv
// Projects Q16.16 points through pinhole intrinsics and tests them against a
// 16-bit depth image held in on-chip memory; the same request port loads the
// image one pixel at a time. A request is taken in every clock cycle (busy is
// high during reset and for the first cycle after it) and its response appears on
// the rsp_ ports for exactly one cycle, marked by rsp_valid; the receiver cannot
// stall, so responses must be taken when shown. Each request passes through
// pipelined restoring dividers, two of 48 stages for the x/z and y/z ratios and
// one of 64 stages for the occlusion tolerance, and through the registered read
// of the depth memory.
// Responses leave in request order. Each depth pixel must be written before a
// point projects onto it; the memory is not cleared after reset.
module point_projection_occlusion_test #(
   parameter int MAX_COLS = ppot_pkg::MAX_COLS_DEF,
   parameter int MAX_ROWS = ppot_pkg::MAX_ROWS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic        req_func,
   input  logic [31:0] req_point_x,
   input  logic [31:0] req_point_y,
   input  logic [31:0] req_point_z,
   input  logic [31:0] req_radius,
   input  logic [8:0]  req_write_col,
   input  logic [8:0]  req_write_row,
   input  logic [15:0] req_depth_raw,
   output logic        rsp_valid,
   output logic [2:0]  rsp_status,
   output logic [9:0]  rsp_pixel_col,
   output logic [9:0]  rsp_pixel_row,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_wdata
);
   import ppot_pkg::*;

   localparam int CW  = $clog2(MAX_COLS);
   localparam int RW  = $clog2(MAX_ROWS);
   localparam int AW  = $clog2(MAX_COLS * MAX_ROWS);
   localparam int CLW = $clog2(MAX_COLS + 1);
   localparam int RLW = $clog2(MAX_ROWS + 1);
   localparam int FTW = $bits(front_tag_type);
   localparam int BTW = $bits(back_tag_type);

   cfg_type cfg;

   logic           busy_ff;
   logic           accept;
   logic [CLW-1:0] cols_eff;
   logic [RLW-1:0] rows_eff;
   logic [31:0]    fmax;

   // Stage A: captured request.
   logic               a_vld_ff;
   logic               a_func_ff;
   logic signed [31:0] a_x_ff;
   logic signed [31:0] a_y_ff;
   logic signed [31:0] a_z_ff;
   logic [31:0]        a_radius_ff;
   logic [8:0]         a_wcol_ff;
   logic [8:0]         a_wrow_ff;
   logic [15:0]        a_wdata_ff;
   logic [31:0]        abs_x;
   logic [31:0]        abs_y;
   logic [31:0]        abs_z;
   front_tag_type      a_tag;

   // Ratio dividers.
   logic          dx_vld;
   logic          dy_vld;
   logic [47:0]   qx;
   logic [47:0]   qy;
   front_tag_type dx_tag;
   logic          dy_sgn;

   // Stages B to E.
   logic               b_vld_ff;
   front_tag_type      b_tag_ff;
   logic signed [31:0] rx_ff;
   logic signed [31:0] ry_ff;
   logic signed [31:0] rx_in;
   logic signed [31:0] ry_in;

   logic               c_vld_ff;
   front_tag_type      c_tag_ff;
   logic signed [63:0] px_ff;
   logic signed [63:0] py_ff;
   logic signed [63:0] px_in;
   logic signed [63:0] py_in;

   logic               d_vld_ff;
   front_tag_type      d_tag_ff;
   logic signed [63:0] col_ff;
   logic signed [63:0] row_ff;
   logic signed [63:0] col_in;
   logic signed [63:0] row_in;

   logic               outside;
   logic               wr_ok;
   logic [AW-1:0]      proj_addr;
   logic [AW-1:0]      wr_addr;
   logic [2:0]         e_status_in;
   logic               e_vld_ff;
   logic [2:0]         e_status_ff;
   logic signed [31:0] e_z_ff;
   logic [31:0]        e_radius_ff;
   logic [9:0]         e_pcol_ff;
   logic [9:0]         e_prow_ff;
   logic               mem_we_ff;
   logic [AW-1:0]      mem_addr_ff;
   logic [15:0]        mem_wdata_ff;
   logic [9:0]         pcol_in;
   logic [9:0]         prow_in;

   // Stages F and G: depth read and scaling.
   logic [15:0]        rd_data;
   logic               f_vld_ff;
   logic [2:0]         f_status_ff;
   logic signed [31:0] f_z_ff;
   logic [31:0]        f_radius_ff;
   logic [9:0]         f_pcol_ff;
   logic [9:0]         f_prow_ff;
   logic [47:0]        depth_in;
   logic [63:0]        rf_in;
   logic               g_vld_ff;
   logic [2:0]         g_status_ff;
   logic signed [31:0] g_z_ff;
   logic [9:0]         g_pcol_ff;
   logic [9:0]         g_prow_ff;
   logic [47:0]        g_depth_ff;
   logic [63:0]        g_rf_ff;
   logic signed [49:0] dz;
   back_tag_type       g_tag;

   // Tolerance divider and the stages after it.
   logic           t_vld;
   logic [63:0]    t_quo;
   logic [BTW-1:0] t_tag;
   logic           h_vld_ff;
   back_tag_type   h_tag_ff;
   logic [63:0]    plo_ff;
   logic [63:0]    phi_ff;
   logic [63:0]    plo_in;
   logic [63:0]    phi_in;
   logic           i_vld_ff;
   back_tag_type   i_tag_ff;
   logic [95:0]    full_ff;
   logic [95:0]    full_in;
   logic           occluded;
   logic [2:0]     status_in;

   logic           rsp_valid_ff;
   logic [2:0]     rsp_status_ff;
   logic [9:0]     rsp_pixel_col_ff;
   logic [9:0]     rsp_pixel_row_ff;

   function automatic logic signed [31:0] sat_ratio(input logic [47:0] mag, input logic neg);
      logic signed [31:0] r;
      if (neg) begin
         if (mag > 48'h0000_8000_0000) begin
            r = {1'b1, 31'b0};
         end else begin
            r = ~mag[31:0] + 32'd1;
         end
      end else begin
         if (mag > 48'h0000_7FFF_FFFF) begin
            r = {1'b0, {31{1'b1}}};
         end else begin
            r = mag[31:0];
         end
      end
      return r;
   endfunction

   ppot_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   assign cols_eff = (cfg.image_cols > MAX_COLS) ? CLW'(MAX_COLS) : CLW'(cfg.image_cols);
   assign rows_eff = (cfg.image_rows > MAX_ROWS) ? RLW'(MAX_ROWS) : RLW'(cfg.image_rows);
   assign fmax     = (cfg.focal_x > cfg.focal_y) ? cfg.focal_x : cfg.focal_y;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b1;
      end else begin
         busy_ff <= 1'b0;
      end
   end

   assign busy   = busy_ff;
   assign accept = start & ~busy_ff;

   // ---------------- Stage A ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         a_vld_ff <= 1'b0;
      end else begin
         a_vld_ff <= accept;
      end
      a_func_ff   <= req_func;
      a_x_ff      <= req_point_x;
      a_y_ff      <= req_point_y;
      a_z_ff      <= req_point_z;
      a_radius_ff <= req_radius;
      a_wcol_ff   <= req_write_col;
      a_wrow_ff   <= req_write_row;
      a_wdata_ff  <= req_depth_raw;
   end

   assign abs_x = a_x_ff[31] ? 32'(-a_x_ff) : 32'(a_x_ff);
   assign abs_y = a_y_ff[31] ? 32'(-a_y_ff) : 32'(a_y_ff);
   assign abs_z = a_z_ff[31] ? 32'(-a_z_ff) : 32'(a_z_ff);

   always_comb begin
      a_tag.proj   = a_func_ff;
      a_tag.near   = (a_z_ff > -NEAR_LIMIT) && (a_z_ff < NEAR_LIMIT);
      a_tag.sgn_x  = a_x_ff[31] ^ a_z_ff[31];
      a_tag.z      = a_z_ff;
      a_tag.radius = a_radius_ff;
      a_tag.wcol   = a_wcol_ff;
      a_tag.wrow   = a_wrow_ff;
      a_tag.wdata  = a_wdata_ff;
   end

   ppot_div #(.NW(48), .DW(32), .TW(FTW)) u_div_x (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (a_vld_ff),
      .num       ({abs_x, 16'b0}),
      .den       (abs_z),
      .tag_in    (a_tag),
      .out_valid (dx_vld),
      .quo       (qx),
      .tag_out   (dx_tag)
   );

   ppot_div #(.NW(48), .DW(32), .TW(1)) u_div_y (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (a_vld_ff),
      .num       ({abs_y, 16'b0}),
      .den       (abs_z),
      .tag_in    (a_y_ff[31] ^ a_z_ff[31]),
      .out_valid (dy_vld),
      .quo       (qy),
      .tag_out   (dy_sgn)
   );

   // ---------------- Stage B: saturated ratios ----------------
   assign rx_in = sat_ratio(qx, dx_tag.sgn_x);
   assign ry_in = sat_ratio(qy, dy_sgn);

   always_ff @(posedge clock) begin
      if (reset) begin
         b_vld_ff <= 1'b0;
      end else begin
         b_vld_ff <= dx_vld & dy_vld;
      end
      b_tag_ff <= dx_tag;
      rx_ff    <= rx_in;
      ry_ff    <= ry_in;
   end

   // ---------------- Stage C: scale by focal length ----------------
   assign px_in = rx_ff * $signed({1'b0, cfg.focal_x});
   assign py_in = ry_ff * $signed({1'b0, cfg.focal_y});

   always_ff @(posedge clock) begin
      if (reset) begin
         c_vld_ff <= 1'b0;
      end else begin
         c_vld_ff <= b_vld_ff;
      end
      c_tag_ff <= b_tag_ff;
      px_ff    <= px_in;
      py_ff    <= py_in;
   end

   // ---------------- Stage D: add principal point ----------------
   // The arithmetic shift floors negative products, as the pixel grid needs.
   assign col_in = (px_ff >>> 16) + $signed({32'b0, cfg.center_x});
   assign row_in = (py_ff >>> 16) + $signed({32'b0, cfg.center_y});

   always_ff @(posedge clock) begin
      if (reset) begin
         d_vld_ff <= 1'b0;
      end else begin
         d_vld_ff <= c_vld_ff;
      end
      d_tag_ff <= c_tag_ff;
      col_ff   <= col_in;
      row_ff   <= row_in;
   end

   // ---------------- Stage E: bounds and memory request ----------------
   assign outside = col_ff[63] || (col_ff[62:16] >= 47'(cols_eff))
                 || row_ff[63] || (row_ff[62:16] >= 47'(rows_eff));
   assign proj_addr = AW'(row_ff[16 +: RW]) * AW'(MAX_COLS) + AW'(col_ff[16 +: CW]);
   assign wr_addr   = AW'(d_tag_ff.wrow) * AW'(MAX_COLS) + AW'(d_tag_ff.wcol);
   assign wr_ok     = (32'(d_tag_ff.wcol) < MAX_COLS) && (32'(d_tag_ff.wrow) < MAX_ROWS);
   assign pcol_in   = col_ff[25:16] + 10'(col_ff[15]);
   assign prow_in   = row_ff[25:16] + 10'(row_ff[15]);

   always_comb begin
      priority if (!d_tag_ff.proj) begin
         e_status_in = ST_WRITTEN;
      end else if (d_tag_ff.near) begin
         e_status_in = ST_NEAR;
      end else if (outside) begin
         e_status_in = ST_OUTSIDE;
      end else begin
         e_status_in = ST_VISIBLE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         e_vld_ff  <= 1'b0;
         mem_we_ff <= 1'b0;
      end else begin
         e_vld_ff  <= d_vld_ff;
         mem_we_ff <= d_vld_ff & ~d_tag_ff.proj & wr_ok;
      end
      e_status_ff  <= e_status_in;
      e_z_ff       <= d_tag_ff.z;
      e_radius_ff  <= d_tag_ff.radius;
      e_pcol_ff    <= pcol_in;
      e_prow_ff    <= prow_in;
      mem_addr_ff  <= d_tag_ff.proj ? proj_addr : wr_addr;
      mem_wdata_ff <= d_tag_ff.wdata;
   end

   // Every request touches the memory at the same stage, so a write is always
   // in place before any later projection reads it.
   ppot_ram #(.WIDTH(16), .DEPTH(MAX_COLS * MAX_ROWS)) u_depth_ram (
      .clock   (clock),
      .wr_en   (mem_we_ff),
      .wr_addr (mem_addr_ff),
      .wr_data (mem_wdata_ff),
      .rd_addr (mem_addr_ff),
      .rd_data (rd_data)
   );

   // ---------------- Stage F: read data arrives ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         f_vld_ff <= 1'b0;
      end else begin
         f_vld_ff <= e_vld_ff;
      end
      f_status_ff <= e_status_ff;
      f_z_ff      <= e_z_ff;
      f_radius_ff <= e_radius_ff;
      f_pcol_ff   <= e_pcol_ff;
      f_prow_ff   <= e_prow_ff;
   end

   assign depth_in = rd_data * cfg.depth_scale;
   assign rf_in    = f_radius_ff * fmax;

   // ---------------- Stage G: depth in metres ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         g_vld_ff <= 1'b0;
      end else begin
         g_vld_ff <= f_vld_ff;
      end
      g_status_ff <= f_status_ff;
      g_z_ff      <= f_z_ff;
      g_pcol_ff   <= f_pcol_ff;
      g_prow_ff   <= f_prow_ff;
      g_depth_ff  <= depth_in;
      g_rf_ff     <= rf_in;
   end

   assign dz = $signed({2'b0, g_depth_ff}) - 50'(g_z_ff);

   always_comb begin
      g_tag.status   = g_status_ff;
      g_tag.depth_nz = (g_depth_ff != '0);
      g_tag.diff     = dz[49] ? 50'(-dz) : 50'(dz);
      g_tag.pcol     = g_pcol_ff;
      g_tag.prow     = g_prow_ff;
   end

   // A zero depth makes the quotient meaningless; such points pass anyway.
   ppot_div #(.NW(64), .DW(48), .TW(BTW)) u_div_t (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (g_vld_ff),
      .num       (g_rf_ff),
      .den       (g_depth_ff),
      .tag_in    (g_tag),
      .out_valid (t_vld),
      .quo       (t_quo),
      .tag_out   (t_tag)
   );

   // ---------------- Stage H: tolerance times scale, in halves ----------------
   assign plo_in = t_quo[31:0] * cfg.depth_scale;
   assign phi_in = t_quo[63:32] * cfg.depth_scale;

   always_ff @(posedge clock) begin
      if (reset) begin
         h_vld_ff <= 1'b0;
      end else begin
         h_vld_ff <= t_vld;
      end
      h_tag_ff <= back_tag_type'(t_tag);
      plo_ff   <= plo_in;
      phi_ff   <= phi_in;
   end

   // ---------------- Stage I: full product ----------------
   assign full_in = {phi_ff, 32'b0} + {32'b0, plo_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         i_vld_ff <= 1'b0;
      end else begin
         i_vld_ff <= h_vld_ff;
      end
      i_tag_ff <= h_tag_ff;
      full_ff  <= full_in;
   end

   // ---------------- Stage J: occlusion decision ----------------
   // A product beyond 64 bits saturates the tolerance, and nothing exceeds it.
   assign occluded = (i_tag_ff.status == ST_VISIBLE) && i_tag_ff.depth_nz
                  && (full_ff[95:64] == '0) && ({14'b0, i_tag_ff.diff} > full_ff[79:16]);
   assign status_in = occluded ? ST_OCCLUDED : i_tag_ff.status;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= i_vld_ff;
      end
      rsp_status_ff    <= status_in;
      rsp_pixel_col_ff <= (status_in == ST_VISIBLE) ? i_tag_ff.pcol : '0;
      rsp_pixel_row_ff <= (status_in == ST_VISIBLE) ? i_tag_ff.prow : '0;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_pixel_col = rsp_pixel_col_ff;
   assign rsp_pixel_row = rsp_pixel_row_ff;

endmodule

### tb/point_projection_occlusion_test_test.sv
`timescale 1ns / 1ps

module point_projection_occlusion_test_test;
   import ppot_pkg::*;

   localparam int IMG_COLS   = 512;
   localparam int IMG_PIXELS = 512 * 512;
   localparam int RSP_LATENCY = 122;
   localparam int STALL_LIMIT = 6000;
   localparam logic [2:0] CSR_UNUSED = 3'd7;

   typedef struct {
      bit          func;
      logic [31:0] x, y, z, radius;
      logic [8:0]  wcol, wrow;
      logic [15:0] draw;
   } request_type;

   typedef struct {
      logic [2:0] status;
      logic [9:0] col, row;
   } response_type;

   typedef struct {
      request_type  q;
      bit           typed;
      response_type r;
   } directed_row_type;

   logic        clock = 0;
   logic        reset = 1;
   logic        start = 0;
   logic        busy;
   logic        req_func = 0;
   logic [31:0] req_point_x = 0, req_point_y = 0, req_point_z = 0, req_radius = 0;
   logic [8:0]  req_write_col = 0, req_write_row = 0;
   logic [15:0] req_depth_raw = 0;
   logic        rsp_valid;
   logic [2:0]  rsp_status;
   logic [9:0]  rsp_pixel_col, rsp_pixel_row;
   logic        csr_valid = 0;
   logic        csr_ready;
   logic [2:0]  csr_index = 0;
   logic [31:0] csr_wdata = 0;

   point_projection_occlusion_test dut (.*);

   always begin
      #4 clock = 1;
      #4 clock = 0;
   end

   // Shadow copy of the camera settings and the depth image.
   logic [31:0] cam_fx = 0, cam_fy = 0, cam_cx = 0, cam_cy = 0, cam_scale = 65536;
   logic [9:0]  cam_cols = 512, cam_rows = 512;
   logic [15:0] depth_img [0:IMG_PIXELS-1];
   bit          pixel_written [0:IMG_PIXELS-1];

   response_type pending_rsp[$];
   int           errors = 0;
   int           idle_pct = 0;
   int           stall_cycles = 0;

   function automatic longint ratio_q16(longint n, longint d);
      longint q;
      q = (n * 65536) / d;
      if (q > 64'sd2147483647) q = 64'sd2147483647;
      if (q < -64'sd2147483648) q = -64'sd2147483648;
      return q;
   endfunction

   function automatic longint place_px(longint r, logic [31:0] f, logic [31:0] c);
      longint p, q;
      p = r * longint'({32'b0, f});
      q = (p >= 0) ? p / 65536 : -((-p + 65535) / 65536);
      return q + longint'({32'b0, c});
   endfunction

   function automatic response_type project_point(request_type q, output int unsigned pix,
                                                  output bit reads);
      longint px, py, pz, col, row, d, ncols, nrows;
      longint unsigned depth, fmax, t, eps, diff;
      response_type o;
      o = '{status: ST_VISIBLE, col: 0, row: 0};
      pix = 0;
      reads = 0;
      px = longint'($signed(q.x));
      py = longint'($signed(q.y));
      pz = longint'($signed(q.z));
      if (pz > -longint'(NEAR_LIMIT) && pz < longint'(NEAR_LIMIT)) begin
         o.status = ST_NEAR;
         return o;
      end
      col = place_px(ratio_q16(px, pz), cam_fx, cam_cx);
      row = place_px(ratio_q16(py, pz), cam_fy, cam_cy);
      ncols = (cam_cols > 512) ? 512 : cam_cols;
      nrows = (cam_rows > 512) ? 512 : cam_rows;
      if (col < 0 || col >= ncols * 65536 || row < 0 || row >= nrows * 65536) begin
         o.status = ST_OUTSIDE;
         return o;
      end
      pix = int'((row / 65536) * IMG_COLS + col / 65536);
      reads = 1;
      if (!pixel_written[pix]) return o;
      depth = {48'b0, depth_img[pix]} * {32'b0, cam_scale};
      if (depth != 0) begin
         fmax = (cam_fx > cam_fy) ? {32'b0, cam_fx} : {32'b0, cam_fy};
         t = ({32'b0, q.radius} * fmax) / depth;
         if (cam_scale == 0 || t == 0)
            eps = 0;
         else if (t > 64'hFFFF_FFFF_FFFF_FFFF / {32'b0, cam_scale})
            eps = 64'hFFFF_FFFF_FFFF_FFFF;
         else
            eps = (t * {32'b0, cam_scale}) >> 16;
         d = longint'(depth) - pz;
         diff = (d < 0) ? -d : d;
         if (diff > eps) begin
            o.status = ST_OCCLUDED;
            return o;
         end
      end
      o.col = 10'((col + 32768) >>> 16);
      o.row = 10'((row + 32768) >>> 16);
      return o;
   endfunction

   task automatic send_request(request_type q, bit typed, response_type typed_rsp);
      response_type r;
      int unsigned pix;
      bit reads;
      while ($urandom_range(99) < idle_pct) begin
         start <= 0;
         @(posedge clock);
      end
      start         <= 1;
      req_func      <= q.func;
      req_point_x   <= q.x;
      req_point_y   <= q.y;
      req_point_z   <= q.z;
      req_radius    <= q.radius;
      req_write_col <= q.wcol;
      req_write_row <= q.wrow;
      req_depth_raw <= q.draw;
      do @(posedge clock); while (busy);
      if (q.func) begin
         r = project_point(q, pix, reads);
      end else begin
         r = '{status: ST_WRITTEN, col: 0, row: 0};
         depth_img[{q.wrow, q.wcol}] = q.draw;
         pixel_written[{q.wrow, q.wcol}] = 1;
      end
      pending_rsp.push_back(typed ? typed_rsp : r);
   endtask

   // A projection onto a pixel is preceded by a write to it if the pixel has no depth yet
   // or refresh is set, with a depth near its z so both outcomes of the test occur.
   task automatic issue(request_type q, bit refresh);
      request_type w;
      response_type r;
      int unsigned pix;
      bit reads;
      longint want;
      if (q.func) begin
         r = project_point(q, pix, reads);
         if (reads && (!pixel_written[pix] || refresh)) begin
            w = q;
            w.func = 0;
            w.wcol = pix[8:0];
            w.wrow = pix[17:9];
            want = (cam_scale != 0 && !q.z[31]) ?
                   longint'({32'b0, q.z}) / longint'({32'b0, cam_scale}) : 0;
            want = want + longint'($urandom_range(6)) - 3;
            if (want < 0 || $urandom_range(7) == 0) want = $urandom_range(65535);
            if (want > 65535) want = 65535;
            w.draw = 16'(want);
            send_request(w, 0, r);
         end
      end
      send_request(q, 0, r);
   endtask

   // The channel drops valid for a cycle after each write, so that back to back
   // writes never assign it twice at one edge.
   task automatic write_csr(logic [2:0] idx, logic [31:0] data);
      csr_valid <= 1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 0;
      case (idx)
         CSR_FOCAL_X:     cam_fx = data;
         CSR_FOCAL_Y:     cam_fy = data;
         CSR_CENTER_X:    cam_cx = data;
         CSR_CENTER_Y:    cam_cy = data;
         CSR_DEPTH_SCALE: cam_scale = data;
         CSR_IMAGE_COLS:  cam_cols = data[9:0];
         CSR_IMAGE_ROWS:  cam_rows = data[9:0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic drain();
      start <= 0;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic set_camera(logic [31:0] fx, fy, cx, cy, sc, ncols, nrows);
      write_csr(CSR_FOCAL_X, fx);
      write_csr(CSR_FOCAL_Y, fy);
      write_csr(CSR_CENTER_X, cx);
      write_csr(CSR_CENTER_Y, cy);
      write_csr(CSR_DEPTH_SCALE, sc);
      write_csr(CSR_IMAGE_COLS, ncols);
      write_csr(CSR_IMAGE_ROWS, nrows);
   endtask

   task automatic random_requests(int count);
      request_type q;
      longint zz, u;
      int kind;
      for (int i = 0; i < count; i++) begin
         q.x = $urandom; q.y = $urandom; q.z = $urandom; q.radius = $urandom;
         q.wcol = $urandom; q.wrow = $urandom; q.draw = $urandom;
         kind = $urandom_range(9);
         q.func = (kind >= 2);
         if (kind == 2 && $urandom_range(3) == 0) q.z = $urandom_range(14) - 7;
         if (kind >= 3) begin
            zz = $urandom_range(20 * 65536, 16384);
            if ($urandom_range(7) == 0) zz = -zz;
            u = longint'($urandom_range(80000)) - 40000;
            q.z = 32'(zz);
            q.x = 32'((zz * u) / 65536);
            u = longint'($urandom_range(80000)) - 40000;
            q.y = 32'((zz * u) / 65536);
            if ($urandom_range(3) != 0) q.radius = $urandom_range(4 * 65536);
         end
         issue(q, $urandom_range(1));
      end
   endtask

   always @(posedge clock) begin
      response_type e;
      if (!reset && rsp_valid) begin
         if (pending_rsp.size() == 0) begin
            $display("%0t: unexpected response status=%0d col=%0d row=%0d",
                     $time, rsp_status, rsp_pixel_col, rsp_pixel_row);
            errors++;
         end else begin
            e = pending_rsp.pop_front();
            if (rsp_status !== e.status) begin
               $display("%0t: status expected %0d actual %0d", $time, e.status, rsp_status);
               errors++;
            end
            if (rsp_pixel_col !== e.col) begin
               $display("%0t: pixel_col expected %0d actual %0d", $time, e.col,
                        rsp_pixel_col);
               errors++;
            end
            if (rsp_pixel_row !== e.row) begin
               $display("%0t: pixel_row expected %0d actual %0d", $time, e.row,
                        rsp_pixel_row);
               errors++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((start && !busy) || rsp_valid || (csr_valid && csr_ready))
         stall_cycles <= 0;
      else
         stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   directed_row_type directed_rows[] = '{
      '{'{0, 0, 0, 0, 0, 9'd0, 9'd0, 16'd0}, 1, '{ST_WRITTEN, 0, 0}},
      '{'{0, 0, 0, 0, 0, 9'd511, 9'd511, 16'hFFFF}, 1, '{ST_WRITTEN, 0, 0}},
      '{'{1, 32'h7FFFFFFF, 32'h80000000, 0, 0, 0, 0, 0}, 1, '{ST_NEAR, 0, 0}},
      '{'{1, 0, 0, 32'd6, 0, 0, 0, 0}, 1, '{ST_NEAR, 0, 0}},
      '{'{1, 0, 0, -32'sd6, 0, 0, 0, 0}, 1, '{ST_NEAR, 0, 0}},
      // Zero stored depth lets the point through whatever its distance.
      '{'{1, 32'h7FFFFFFF, 32'h80000000, 32'h80000000, 0, 0, 0, 0}, 1,
        '{ST_VISIBLE, 0, 0}},
      '{'{1, 32'h80000000, 32'h7FFFFFFF, 32'd7, 32'hFFFFFFFF, 0, 0, 0}, 1,
        '{ST_VISIBLE, 0, 0}},
      '{'{0, 0, 0, 0, 0, 9'd0, 9'd0, 16'hFFFF}, 1, '{ST_WRITTEN, 0, 0}},
      '{'{1, 0, 0, 32'd7, 32'hFFFFFFFF, 0, 0, 0}, 1, '{ST_OCCLUDED, 0, 0}},
      '{'{1, 0, 0, 32'h7FFFFFFF, 0, 0, 0, 0}, 1, '{ST_OCCLUDED, 0, 0}},
      '{'{0, 0, 0, 0, 0, 9'd0, 9'd0, 16'd1}, 1, '{ST_WRITTEN, 0, 0}},
      '{'{1, 0, 0, 32'd65536, 32'd5, 0, 0, 0}, 1, '{ST_VISIBLE, 0, 0}},
      '{'{1, 0, 0, -32'sd7, 0, 0, 0, 0}, 1, '{ST_OCCLUDED, 0, 0}},
      '{'{0, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 9'd300, 9'd17,
          16'hA5A5}, 0, '{0, 0, 0}},
      '{'{1, -32'sd65536, 32'd65536, -32'sd65536, 32'hFFFFFFFF, 9'h1FF, 9'h1FF,
          16'hFFFF}, 0, '{0, 0, 0}}
   };

   initial begin
      repeat (12) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      foreach (directed_rows[i])
         send_request(directed_rows[i].q, directed_rows[i].typed, directed_rows[i].r);
      drain();

      idle_pct = 35;
      set_camera(32'd256 << 16, 32'd256 << 16, 32'd256 << 16, 32'd256 << 16, 32'd66,
                 32'd512, 32'd512);
      write_csr(CSR_UNUSED, 32'hDEADBEEF);  // beyond the last register; must be ignored
      random_requests(300);
      drain();
      set_camera(32'd200 << 16, 32'd400 << 16, 32'h0028_8000, 32'd30 << 16, 32'd65536,
                 32'd100, 32'd60);
      random_requests(250);
      drain();

      idle_pct = 70;
      set_camera(32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF,
                 32'hFFFFFFFF, 32'd1);
      random_requests(120);
      drain();
      set_camera(0, 32'd50 << 16, 32'd8 << 16, 32'd8 << 16, 0, 0, 32'd512);
      random_requests(60);
      drain();

      idle_pct = 0;
      set_camera(32'd1 << 16, 32'd3 << 16, 0, 32'h0001_8000, 32'd1000, 32'd1, 32'd16);
      random_requests(100);
      drain();
      set_camera(32'd300 << 16, 32'd300 << 16, 32'd320 << 16, 32'd240 << 16, 32'd66,
                 32'd512, 32'd480);
      random_requests(200);
      drain();

      repeat (RSP_LATENCY + 8) @(posedge clock);
      if (errors == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule
